[sv/rkfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotary knob frequency setpoint package
// Phase codes, step kinds, register indexes and step constants.
// ----------------------------------------------------------------------------
package rkfs_pkg;

    localparam int FREQ_W   = 23;
    localparam int SETTLE_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam int FREQ_BITS = 23;
    localparam logic [FREQ_W-1:0] START_FREQ = 23'd100000;

    localparam logic [FREQ_W:0] SAT_TOP = (FREQ_BITS >= FREQ_W)
        ? {1'b0, {FREQ_W{1'b1}}}
        : (FREQ_W+1)'((64'd1 << FREQ_BITS) - 64'd1);

    localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS = 24'd10000;
    localparam logic [FREQ_W-1:0]   RST_MIN_FREQ     = 23'd5000;
    localparam logic [FREQ_W-1:0]   RST_MAX_FREQ     = 23'd5000000;

    localparam logic [FREQ_W-1:0] STEP_SMALL = 23'd1000;
    localparam logic [FREQ_W-1:0] STEP_MID   = 23'd10000;
    localparam logic [FREQ_W-1:0] STEP_LARGE = 23'd100000;

    localparam logic [FREQ_W-1:0] DECADE_LOW  = 23'd10000;
    localparam logic [FREQ_W-1:0] DECADE_HIGH = 23'd100000;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ     = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE1,
        PH_RELEASE1,
        PH_SETTLE2,
        PH_RELEASE2,
        PH_PUSH_SETTLE,
        PH_PUSH_RELEASE
    } t_phase;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } t_step_kind;

endpackage
`default_nettype wire

[sv/rotary_knob_frequency_setpoint.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotary knob frequency setpoint
// Decodes knob contact samples into frequency steps and toggles the leading
// channel flag on a push; one result item for every sample item.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  sample   | i_in_valid / o_in_ready   | i_contact_a, i_contact_b, i_push_button
//  result   | o_out_valid / i_out_ready | o_setpoint, o_b_leads, o_update,
//           |                           | o_step_kind
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  One item per cycle while the result channel is not stalled; the result appears in the cycle after acceptance.
//  The state update and the result register load on the same edge.
//  A held result stalls input only when i_out_ready is low.
//  Reset restores the register defaults and the idle phase; no clearing pass.
// ----------------------------------------------------------------------------
module rotary_knob_frequency_setpoint (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_contact_a,
    input  wire logic        i_contact_b,
    input  wire logic        i_push_button,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [22:0]      o_setpoint,
    output logic             o_b_leads,
    output logic             o_update,
    output logic [1:0]       o_step_kind,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    rkfs_pkg::t_phase     r_phase, n_phase;
    logic                 r_a_fell, n_a_fell;
    logic                 r_b_fell, n_b_fell;
    logic [22:0]          r_freq, n_freq;
    logic                 r_lead, n_lead;
    logic [23:0]          r_wait, n_wait;
    logic [23:0]          r_settle;
    logic [22:0]          r_min, r_max;

    logic                 r_out_valid;
    logic [22:0]          r_setpoint;
    logic                 r_b_leads;
    logic                 r_update;
    rkfs_pkg::t_step_kind r_kind, n_kind;
    logic                 n_update;

    logic a_low, b_low, both_high, accept;
    logic latch_a, step_up, a_after, latch_b, step_down, push_act;
    logic settle_zero, settle_done, is_settle;
    logic [22:0] up_inc, dn_dec, up_val, dn_val;
    logic [23:0] up_sum;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign a_low     = !i_contact_a;
    assign b_low     = !i_contact_b;
    assign both_high = i_contact_a && i_contact_b;

    assign latch_a   = a_low && !r_b_fell && !r_a_fell;
    assign step_up   = a_low && r_b_fell && !r_a_fell;
    assign a_after   = r_a_fell || latch_a;
    assign latch_b   = !step_up && b_low && !a_after && !r_b_fell;
    assign step_down = !step_up && b_low && a_after && !r_b_fell;
    assign push_act  = !step_up && !step_down && i_push_button;

    assign settle_zero = (r_settle == '0);
    assign settle_done = (r_wait <= 24'd1);
    assign is_settle   = (r_phase == rkfs_pkg::PH_SETTLE1) ||
                         (r_phase == rkfs_pkg::PH_SETTLE2) ||
                         (r_phase == rkfs_pkg::PH_PUSH_SETTLE);

    // step up: decade step, wrap to the minimum at or above the maximum, saturate at the top
    always_comb begin
        if (r_freq < rkfs_pkg::DECADE_LOW) begin
            up_inc = rkfs_pkg::STEP_SMALL;
        end else if (r_freq < rkfs_pkg::DECADE_HIGH) begin
            up_inc = rkfs_pkg::STEP_MID;
        end else begin
            up_inc = rkfs_pkg::STEP_LARGE;
        end
        up_sum = {1'b0, r_freq} + {1'b0, up_inc};
        if (r_freq >= r_max) begin
            up_val = r_min;
        end else if (up_sum > rkfs_pkg::SAT_TOP) begin
            up_val = rkfs_pkg::SAT_TOP[22:0];
        end else begin
            up_val = up_sum[22:0];
        end
    end

    // step down: decade step, wrap to the maximum at or below the minimum, floor at zero
    always_comb begin
        if (r_freq <= rkfs_pkg::DECADE_LOW) begin
            dn_dec = rkfs_pkg::STEP_SMALL;
        end else if (r_freq <= rkfs_pkg::DECADE_HIGH) begin
            dn_dec = rkfs_pkg::STEP_MID;
        end else begin
            dn_dec = rkfs_pkg::STEP_LARGE;
        end
        if (r_freq <= r_min) begin
            dn_val = r_max;
        end else if (r_freq > dn_dec) begin
            dn_val = r_freq - dn_dec;
        end else begin
            dn_val = '0;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            rkfs_pkg::PH_IDLE: begin
                if (step_up || step_down) begin
                    n_phase = settle_zero ? rkfs_pkg::PH_RELEASE1 : rkfs_pkg::PH_SETTLE1;
                end else if (push_act) begin
                    n_phase = settle_zero ? rkfs_pkg::PH_PUSH_RELEASE
                                          : rkfs_pkg::PH_PUSH_SETTLE;
                end
            end
            rkfs_pkg::PH_SETTLE1: begin
                if (settle_done) n_phase = rkfs_pkg::PH_RELEASE1;
            end
            rkfs_pkg::PH_SETTLE2: begin
                if (settle_done) n_phase = rkfs_pkg::PH_RELEASE2;
            end
            rkfs_pkg::PH_PUSH_SETTLE: begin
                if (settle_done) n_phase = rkfs_pkg::PH_PUSH_RELEASE;
            end
            rkfs_pkg::PH_RELEASE1: begin
                if (both_high) begin
                    n_phase = settle_zero ? rkfs_pkg::PH_RELEASE2 : rkfs_pkg::PH_SETTLE2;
                end
            end
            rkfs_pkg::PH_RELEASE2: begin
                if (both_high) n_phase = rkfs_pkg::PH_IDLE;
            end
            rkfs_pkg::PH_PUSH_RELEASE: begin
                if (!i_push_button) n_phase = rkfs_pkg::PH_IDLE;
            end
            default: n_phase = rkfs_pkg::PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_a_fell = r_a_fell;
        n_b_fell = r_b_fell;
        n_freq   = r_freq;
        n_lead   = r_lead;
        n_wait   = r_wait;
        n_kind   = rkfs_pkg::STEP_NONE;
        n_update = 1'b0;
        if (r_phase == rkfs_pkg::PH_IDLE) begin
            n_a_fell = a_after;
            n_b_fell = r_b_fell || latch_b;
            if (step_up) begin
                n_freq = up_val;
                n_kind = rkfs_pkg::STEP_UP;
            end else if (step_down) begin
                n_freq = dn_val;
                n_kind = rkfs_pkg::STEP_DOWN;
            end
            if (step_up || step_down || push_act) begin
                n_update = 1'b1;
                n_wait   = r_settle;
            end
            if (push_act) begin
                n_lead = !r_lead;
            end
        end else if (is_settle) begin
            if (r_wait != '0) n_wait = r_wait - 24'd1;
        end else if (r_phase == rkfs_pkg::PH_RELEASE1) begin
            if (both_high) n_wait = r_settle;
        end else if (r_phase == rkfs_pkg::PH_RELEASE2) begin
            if (both_high) begin
                n_a_fell = 1'b0;
                n_b_fell = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rkfs_pkg::PH_IDLE;
            r_a_fell    <= 1'b0;
            r_b_fell    <= 1'b0;
            r_freq      <= rkfs_pkg::START_FREQ;
            r_lead      <= 1'b0;
            r_wait      <= '0;
            r_settle    <= rkfs_pkg::RST_SETTLE_TICKS;
            r_min       <= rkfs_pkg::RST_MIN_FREQ;
            r_max       <= rkfs_pkg::RST_MAX_FREQ;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rkfs_pkg::CFG_SETTLE_TICKS: r_settle <= i_cfg_data;
                    rkfs_pkg::CFG_MIN_FREQ:     r_min    <= i_cfg_data[22:0];
                    rkfs_pkg::CFG_MAX_FREQ:     r_max    <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_a_fell <= n_a_fell;
                r_b_fell <= n_b_fell;
                r_freq   <= n_freq;
                r_lead   <= n_lead;
                r_wait   <= n_wait;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_setpoint <= n_freq;
            r_b_leads  <= n_lead;
            r_update   <= n_update;
            r_kind     <= n_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_setpoint  = r_setpoint;
    assign o_b_leads   = r_b_leads;
    assign o_update    = r_update;
    assign o_step_kind = r_kind;

    a_step_sets_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != rkfs_pkg::STEP_NONE) |-> r_update)
        else $error("step without update");

    a_step_enters_release_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != rkfs_pkg::STEP_NONE) |->
        (r_phase == rkfs_pkg::PH_SETTLE1 || r_phase == rkfs_pkg::PH_RELEASE1))
        else $error("step did not enter settle");

    a_push_enters_push_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_update && r_kind == rkfs_pkg::STEP_NONE) |->
        (r_phase == rkfs_pkg::PH_PUSH_SETTLE || r_phase == rkfs_pkg::PH_PUSH_RELEASE))
        else $error("toggle did not enter push settle");

    a_latch_in_step_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rkfs_pkg::PH_SETTLE1 || r_phase == rkfs_pkg::PH_RELEASE1 ||
         r_phase == rkfs_pkg::PH_SETTLE2 || r_phase == rkfs_pkg::PH_RELEASE2) |->
        (r_a_fell && r_b_fell) || (r_a_fell != r_b_fell))
        else $error("no contact latch during release sequence");

endmodule
`default_nettype wire

[tb/tb_rotary_knob_frequency_setpoint.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob frequency setpoint testbench
// Drives knob contact and push button samples through the sample channel.
// A scoreboard tracks the phase, the fall-order latches, the setpoint and the
// leading flag of the knob and checks every result item field by field.
// Runs a directed pass, then random detent turns, feints, pushes and noise
// under several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_rotary_knob_frequency_setpoint;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [rkfs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam longint unsigned BITS_TOP = (64'd1 << rkfs_pkg::FREQ_BITS) - 64'd1;
    localparam longint unsigned FIELD_TOP = (64'd1 << rkfs_pkg::FREQ_W) - 64'd1;

    localparam int DRILL_LEN = 20;
    // {contact_a, contact_b, push_button} per item, first item leftmost
    localparam logic [3*DRILL_LEN-1:0] DRILL = {
        3'b100, 3'b000, 3'b000, 3'b111, 3'b110,
        3'b010, 3'b000, 3'b110, 3'b110, 3'b000,
        3'b110, 3'b110, 3'b111, 3'b111, 3'b110,
        3'b101, 3'b110, 3'b001, 3'b111, 3'b110
    };

    typedef struct packed {
        logic [rkfs_pkg::FREQ_W-1:0] setpoint;
        logic                        b_leads;
        logic                        update;
        rkfs_pkg::t_step_kind        kind;
    } t_knob_result;

    class setpoint_scoreboard;
        rkfs_pkg::t_phase              phase;
        logic                          a_first;
        logic                          b_first;
        logic [rkfs_pkg::FREQ_W-1:0]   freq;
        logic                          lead;
        logic [rkfs_pkg::SETTLE_W-1:0] wait_left;
        logic [rkfs_pkg::SETTLE_W-1:0] settle_ticks;
        logic [rkfs_pkg::FREQ_W-1:0]   fmin;
        logic [rkfs_pkg::FREQ_W-1:0]   fmax;
        t_knob_result                  due_results[$];
        int                            live_items;
        int                            errors;

        function new();
            phase = rkfs_pkg::PH_IDLE;
            a_first = 1'b0;
            b_first = 1'b0;
            freq = rkfs_pkg::START_FREQ;
            lead = 1'b0;
            wait_left = '0;
            settle_ticks = rkfs_pkg::RST_SETTLE_TICKS;
            fmin = rkfs_pkg::RST_MIN_FREQ;
            fmax = rkfs_pkg::RST_MAX_FREQ;
            live_items = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [rkfs_pkg::CFG_IDX_W-1:0] idx,
                                logic [rkfs_pkg::SETTLE_W-1:0] data);
            case (idx)
                rkfs_pkg::CFG_SETTLE_TICKS: settle_ticks = data;
                rkfs_pkg::CFG_MIN_FREQ:     fmin = data[rkfs_pkg::FREQ_W-1:0];
                rkfs_pkg::CFG_MAX_FREQ:     fmax = data[rkfs_pkg::FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [rkfs_pkg::FREQ_W-1:0] stepped_up(logic [rkfs_pkg::FREQ_W-1:0] f);
            longint unsigned sum;
            if (f >= fmax)
                return fmin;
            if (f < rkfs_pkg::DECADE_LOW)
                sum = 64'(f) + 64'(rkfs_pkg::STEP_SMALL);
            else if (f < rkfs_pkg::DECADE_HIGH)
                sum = 64'(f) + 64'(rkfs_pkg::STEP_MID);
            else
                sum = 64'(f) + 64'(rkfs_pkg::STEP_LARGE);
            if (sum > BITS_TOP)
                sum = BITS_TOP;
            if (sum > FIELD_TOP)
                sum = FIELD_TOP;
            return sum[rkfs_pkg::FREQ_W-1:0];
        endfunction

        function logic [rkfs_pkg::FREQ_W-1:0] stepped_down(logic [rkfs_pkg::FREQ_W-1:0] f);
            logic [rkfs_pkg::FREQ_W-1:0] d;
            if (f <= fmin)
                return fmax;
            if (f <= rkfs_pkg::DECADE_LOW)
                d = rkfs_pkg::STEP_SMALL;
            else if (f <= rkfs_pkg::DECADE_HIGH)
                d = rkfs_pkg::STEP_MID;
            else
                d = rkfs_pkg::STEP_LARGE;
            return (f > d) ? f - d : '0;
        endfunction

        // skip the settle phase entirely when no settle time is set
        function void enter_settle(rkfs_pkg::t_phase settle_ph, rkfs_pkg::t_phase release_ph);
            wait_left = settle_ticks;
            phase = (settle_ticks == 0) ? release_ph : settle_ph;
        endfunction

        function void count_down();
            if (wait_left != 0)
                wait_left--;
            if (wait_left == 0) begin
                case (phase)
                    rkfs_pkg::PH_SETTLE1: phase = rkfs_pkg::PH_RELEASE1;
                    rkfs_pkg::PH_SETTLE2: phase = rkfs_pkg::PH_RELEASE2;
                    default:              phase = rkfs_pkg::PH_PUSH_RELEASE;
                endcase
            end
        endfunction

        function void note_sample(logic a, logic b, logic p);
            logic a_low;
            logic b_low;
            t_knob_result r;
            a_low = !a;
            b_low = !b;
            r.kind = rkfs_pkg::STEP_NONE;
            r.update = 1'b0;
            live_items++;
            case (phase)
                rkfs_pkg::PH_IDLE: begin
                    if (a_low && !a_first && !b_first) begin
                        a_first = 1'b1;
                    end else if (a_low && b_first && !a_first) begin
                        freq = stepped_up(freq);
                        r.kind = rkfs_pkg::STEP_UP;
                    end
                    // both falling on one sample: A latches, then B steps down
                    if (r.kind == rkfs_pkg::STEP_NONE) begin
                        if (b_low && !a_first && !b_first) begin
                            b_first = 1'b1;
                        end else if (b_low && a_first && !b_first) begin
                            freq = stepped_down(freq);
                            r.kind = rkfs_pkg::STEP_DOWN;
                        end
                    end
                    if (r.kind != rkfs_pkg::STEP_NONE) begin
                        r.update = 1'b1;
                        enter_settle(rkfs_pkg::PH_SETTLE1, rkfs_pkg::PH_RELEASE1);
                    end else if (p) begin
                        lead = !lead;
                        r.update = 1'b1;
                        enter_settle(rkfs_pkg::PH_PUSH_SETTLE, rkfs_pkg::PH_PUSH_RELEASE);
                    end
                end
                rkfs_pkg::PH_SETTLE1, rkfs_pkg::PH_SETTLE2,
                rkfs_pkg::PH_PUSH_SETTLE: count_down();
                rkfs_pkg::PH_RELEASE1: begin
                    if (a && b)
                        enter_settle(rkfs_pkg::PH_SETTLE2, rkfs_pkg::PH_RELEASE2);
                end
                rkfs_pkg::PH_RELEASE2: begin
                    if (a && b) begin
                        a_first = 1'b0;
                        b_first = 1'b0;
                        phase = rkfs_pkg::PH_IDLE;
                    end
                end
                rkfs_pkg::PH_PUSH_RELEASE: begin
                    if (!p)
                        phase = rkfs_pkg::PH_IDLE;
                end
                default: phase = rkfs_pkg::PH_IDLE;
            endcase
            r.setpoint = freq;
            r.b_leads = lead;
            due_results.push_back(r);
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic [rkfs_pkg::FREQ_W-1:0] sp, logic bl, logic upd,
                                   logic [1:0] kind);
            t_knob_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result with no sample pending: expected none, actual %0d",
                         $time, sp);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (sp !== want.setpoint)
                mismatch("setpoint", 32'(want.setpoint), 32'(sp));
            if (bl !== want.b_leads)
                mismatch("b_leads", 32'(want.b_leads), 32'(bl));
            if (upd !== want.update)
                mismatch("update", 32'(want.update), 32'(upd));
            if (kind !== want.kind)
                mismatch("step_kind", 32'(want.kind), 32'(kind));
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           i_contact_a = 1'b1;
    logic                           i_contact_b = 1'b1;
    logic                           i_push_button = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [rkfs_pkg::FREQ_W-1:0]    o_setpoint;
    logic                           o_b_leads;
    logic                           o_update;
    logic [1:0]                     o_step_kind;
    logic                           i_cfg_we = 1'b0;
    logic [rkfs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rkfs_pkg::SETTLE_W-1:0]  i_cfg_data = '0;

    setpoint_scoreboard sb;
    int send_idle_pct = 17;
    int recv_idle_pct = 75;
    int hold_reqs = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int cycles = 0;

    rotary_knob_frequency_setpoint dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_contact_a   (i_contact_a),
        .i_contact_b   (i_contact_b),
        .i_push_button (i_push_button),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_setpoint    (o_setpoint),
        .o_b_leads     (o_b_leads),
        .o_update      (o_update),
        .o_step_kind   (o_step_kind),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_taken != hold_reqs) begin
            hold_taken <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_setpoint, o_b_leads, o_update, o_step_kind);
            if (i_in_valid && o_in_ready)
                sb.note_sample(i_contact_a, i_contact_b, i_push_button);
        end
    end

    task automatic send_item(input logic a, input logic b, input logic p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_contact_a <= a;
        i_contact_b <= b;
        i_push_button <= p;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rkfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rkfs_pkg::SETTLE_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic retune(input logic [rkfs_pkg::SETTLE_W-1:0] settle,
                          input logic [rkfs_pkg::SETTLE_W-1:0] lo,
                          input logic [rkfs_pkg::SETTLE_W-1:0] hi);
        wait_quiet();
        write_reg(rkfs_pkg::CFG_SETTLE_TICKS, settle);
        write_reg(rkfs_pkg::CFG_MIN_FREQ, lo);
        write_reg(rkfs_pkg::CFG_MAX_FREQ, hi);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int settle_span();
        return (sb.settle_ticks > 200) ? 200 : int'(sb.settle_ticks);
    endfunction

    // detent turn; a feint drops the first contact and releases it again
    task automatic knob_turn(input logic feint);
        logic up;
        int span;
        up = 1'($urandom_range(0, 1));
        span = settle_span();
        repeat ($urandom_range(0, 2)) send_item(1'b1, 1'b1, 1'b0);
        repeat ($urandom_range(1, 2)) send_item(up, !up, 1'b0);
        if (!feint) begin
            repeat ($urandom_range(1, span + 3)) send_item(1'b0, 1'b0, 1'b0);
            repeat ($urandom_range(0, 2)) send_item(!up, up, 1'b0);
        end
        repeat ($urandom_range(1, 2 * span + 6))
            send_item(1'b1, 1'b1, $urandom_range(0, 15) == 0);
    endtask

    task automatic knob_push();
        int span;
        span = settle_span();
        repeat ($urandom_range(1, span + 4)) send_item(1'b1, 1'b1, 1'b1);
        repeat ($urandom_range(1, span + 3)) send_item(1'b1, 1'b1, 1'b0);
    endtask

    task automatic wander(input int count);
        int goal;
        int pick;
        goal = sb.live_items + count;
        while (sb.live_items < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                knob_turn(1'b0);
            else if (pick < 75)
                knob_turn(1'b1);
            else if (pick < 85)
                knob_push();
            else
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [2:0] drill_item;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        repeat (3) send_item(1'b1, 1'b1, 1'b0);
        retune(0, 24'(rkfs_pkg::RST_MIN_FREQ), 24'(rkfs_pkg::RST_MAX_FREQ));
        for (int i = 0; i < DRILL_LEN; i++) begin
            drill_item = DRILL[3*(DRILL_LEN-1-i) +: 3];
            send_item(drill_item[2], drill_item[1], drill_item[0]);
        end

        retune(2, 24'(rkfs_pkg::RST_MIN_FREQ), 24'(rkfs_pkg::RST_MAX_FREQ));
        wander(200);
        retune(0, 1, 24'hFFFFFF);
        wander(250);
        retune(1, 0, 500);
        wander(150);

        send_idle_pct = 75;
        recv_idle_pct = 17;
        retune(150, 8388000, 8388607);
        wander(120);
        retune(3, 200000, 50000);
        wander(250);
        retune(0, 12345, 12345);
        wander(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // return to idle before the longest settle time is loaded
        repeat (4) send_item(1'b1, 1'b1, 1'b0);
        retune(24'hFFFFFF, 24'(rkfs_pkg::RST_MIN_FREQ), 24'(rkfs_pkg::RST_MAX_FREQ));
        repeat (8) send_item(1'b1, 1'b1, 1'b0);
        wait_quiet();
        write_reg(CFG_SPARE, 24'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);

        retune(1, 9000, 105000);
        wander(40);
        hold_reqs++;
        wander(210);
        retune(4, 24'(rkfs_pkg::RST_MIN_FREQ), 24'(rkfs_pkg::RST_MAX_FREQ));
        wander(150);
        retune(24'($urandom_range(0, 6)), 24'($urandom_range(1, 300000)),
               24'($urandom_range(1, 8388607)));
        wander(200);

        wait_quiet();
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
